[design/crh_pkg.sv]
`default_nettype none
package crh_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int NODES_DEF   = 1024;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int NAME_W   = 32;
    localparam int SLOT_W   = 10;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_READ,
        ST_CHECK,
        ST_UNLINK,
        ST_FRONT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic read_head;
        logic read_node;
        logic check;
        logic unlink;
        logic front;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_insert;
        logic is_lookup;
        logic is_delete;
        logic link_end;
        logic hit;
        logic has_prev;
    } status_t;

endpackage
`default_nettype wire

[design/crh_ctrl.sv]
`default_nettype none
module crh_ctrl
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             start,
    input  crh_pkg::status_t st,
    output crh_pkg::cmd_t    cmd,
    output logic            busy
);

    crh_pkg::state_t state_reg;
    crh_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crh_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crh_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = crh_pkg::ST_HEAD;
                end
            end
            crh_pkg::ST_HEAD:
            begin
                if (st.is_insert || (!st.is_lookup && !st.is_delete))
                begin
                    state_next = crh_pkg::ST_DONE;
                end
                else
                begin
                    state_next = crh_pkg::ST_READ;
                end
            end
            crh_pkg::ST_READ:
            begin
                if (st.link_end)
                begin
                    state_next = crh_pkg::ST_DONE;
                end
                else
                begin
                    state_next = crh_pkg::ST_CHECK;
                end
            end
            crh_pkg::ST_CHECK:
            begin
                if (st.hit)
                begin
                    if (st.is_delete || st.has_prev)
                    begin
                        state_next = crh_pkg::ST_UNLINK;
                    end
                    else
                    begin
                        state_next = crh_pkg::ST_DONE;
                    end
                end
                else
                begin
                    state_next = crh_pkg::ST_READ;
                end
            end
            crh_pkg::ST_UNLINK:
            begin
                if (st.is_lookup)
                begin
                    state_next = crh_pkg::ST_FRONT;
                end
                else
                begin
                    state_next = crh_pkg::ST_DONE;
                end
            end
            crh_pkg::ST_FRONT:
            begin
                state_next = crh_pkg::ST_DONE;
            end
            crh_pkg::ST_DONE:
            begin
                state_next = crh_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = crh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != crh_pkg::ST_IDLE);
        case (state_reg)
            crh_pkg::ST_IDLE:   cmd.load      = start;
            crh_pkg::ST_HEAD:   cmd.read_head = 1'b1;
            crh_pkg::ST_READ:   cmd.read_node = 1'b1;
            crh_pkg::ST_CHECK:  cmd.check     = 1'b1;
            crh_pkg::ST_UNLINK: cmd.unlink    = 1'b1;
            crh_pkg::ST_FRONT:  cmd.front     = 1'b1;
            crh_pkg::ST_DONE:   cmd.finish    = 1'b1;
            default:            cmd           = '0;
        endcase
    end

endmodule
`default_nettype wire

[design/crh_dp.sv]
`default_nettype none
module crh_dp
#(
    parameter int BUCKETS = crh_pkg::BUCKETS_DEF,
    parameter int NODES   = crh_pkg::NODES_DEF
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  crh_pkg::cmd_t                cmd,
    input  wire [crh_pkg::KIND_W-1:0]    kind,
    input  wire [crh_pkg::KEY_W-1:0]     space_id,
    input  wire [crh_pkg::KEY_W-1:0]     object_id,
    input  wire [crh_pkg::NAME_W-1:0]    port_name_in,
    input  wire [crh_pkg::SLOT_W-1:0]    entry_slot_in,
    output crh_pkg::status_t             st,
    output logic                         done,
    output logic                         found,
    output logic [crh_pkg::NAME_W-1:0]   port_name_out,
    output logic [crh_pkg::SLOT_W-1:0]   entry_slot_out
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = $clog2(NODES + 1);
    localparam int CW = $clog2(NODES + 1);
    localparam int SW = (crh_pkg::SLOT_W > LW) ? crh_pkg::SLOT_W : LW;

    logic [LW-1:0] head_mem [BUCKETS];
    logic          head_vld_reg [BUCKETS];
    logic [crh_pkg::KEY_W-1:0]  sp_mem [NODES];
    logic [crh_pkg::KEY_W-1:0]  ob_mem [NODES];
    logic [crh_pkg::NAME_W-1:0] nm_mem [NODES];
    logic [LW-1:0]              nx_mem [NODES];

    logic [crh_pkg::KIND_W-1:0] kind_reg;
    logic [crh_pkg::KEY_W-1:0]  sp_reg;
    logic [crh_pkg::KEY_W-1:0]  ob_reg;
    logic [crh_pkg::NAME_W-1:0] nm_reg;
    logic [crh_pkg::SLOT_W-1:0] slot_reg;
    logic [BW-1:0]              bkt_reg;
    logic [LW-1:0]              head_reg;
    logic [LW-1:0]              link_reg;
    logic [NW-1:0]              cur_reg;
    logic [NW-1:0]              prev_reg;
    logic                       has_prev_reg;
    logic [CW-1:0]              steps_reg;
    logic [crh_pkg::KEY_W-1:0]  rd_sp_reg;
    logic [crh_pkg::KEY_W-1:0]  rd_ob_reg;
    logic [crh_pkg::NAME_W-1:0] rd_nm_reg;
    logic [LW-1:0]              rd_nx_reg;
    logic                       hit_reg;

    logic [crh_pkg::KEY_W-1:0]  hsum;
    logic [BW-1:0]              bkt_in;
    logic                       slot_ok;
    logic [LW-1:0]              cur_link;
    logic                       hit_now;

    assign hsum     = (space_id >> 4) + (object_id >> 6);
    assign bkt_in   = hsum[BW-1:0] & BW'(BUCKETS - 1);
    assign slot_ok  = SW'(slot_reg) < SW'(NODES);
    assign cur_link = LW'(cur_reg) + LW'(1);
    assign hit_now  = (kind_reg == crh_pkg::KIND_LOOKUP)
                      ? (rd_ob_reg == ob_reg && rd_sp_reg == sp_reg)
                      : (SW'(slot_reg) == SW'(cur_reg));

    assign st.is_insert = (kind_reg == crh_pkg::KIND_INSERT) && slot_ok;
    assign st.is_lookup = (kind_reg == crh_pkg::KIND_LOOKUP);
    assign st.is_delete = (kind_reg == crh_pkg::KIND_DELETE);
    assign st.link_end  = (link_reg == '0) || (steps_reg >= CW'(NODES));
    assign st.hit       = hit_now;
    assign st.has_prev  = has_prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
            begin
                head_vld_reg[i] <= 1'b0;
            end
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
            if (cmd.read_head && st.is_insert)
            begin
                head_vld_reg[bkt_reg] <= 1'b1;
            end
            if (cmd.unlink && !has_prev_reg)
            begin
                head_vld_reg[bkt_reg] <= 1'b1;
            end
            if (cmd.front)
            begin
                head_vld_reg[bkt_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            sp_reg   <= space_id;
            ob_reg   <= object_id;
            nm_reg   <= port_name_in;
            slot_reg <= entry_slot_in;
            bkt_reg  <= bkt_in;
            head_reg <= head_vld_reg[bkt_in] ? head_mem[bkt_in] : '0;
            hit_reg  <= 1'b0;
        end
        if (cmd.read_head)
        begin
            link_reg     <= head_reg;
            has_prev_reg <= 1'b0;
            steps_reg    <= '0;
            if (st.is_insert)
            begin
                sp_mem[slot_reg[NW-1:0]] <= sp_reg;
                ob_mem[slot_reg[NW-1:0]] <= ob_reg;
                nm_mem[slot_reg[NW-1:0]] <= nm_reg;
                nx_mem[slot_reg[NW-1:0]] <= head_reg;
                head_mem[bkt_reg]        <= LW'(slot_reg[NW-1:0]) + LW'(1);
                hit_reg                  <= 1'b1;
            end
        end
        if (cmd.read_node && !st.link_end)
        begin
            cur_reg   <= NW'(link_reg - LW'(1));
            rd_sp_reg <= sp_mem[NW'(link_reg - LW'(1))];
            rd_ob_reg <= ob_mem[NW'(link_reg - LW'(1))];
            rd_nm_reg <= nm_mem[NW'(link_reg - LW'(1))];
            rd_nx_reg <= nx_mem[NW'(link_reg - LW'(1))];
        end
        if (cmd.check)
        begin
            if (hit_now)
            begin
                hit_reg <= 1'b1;
            end
            else
            begin
                prev_reg     <= cur_reg;
                has_prev_reg <= 1'b1;
                link_reg     <= rd_nx_reg;
                steps_reg    <= steps_reg + CW'(1);
            end
        end
        if (cmd.unlink)
        begin
            if (has_prev_reg)
            begin
                nx_mem[prev_reg] <= rd_nx_reg;
            end
            else
            begin
                head_mem[bkt_reg] <= rd_nx_reg;
            end
        end
        if (cmd.front)
        begin
            nx_mem[cur_reg]   <= head_reg;
            head_mem[bkt_reg] <= cur_link;
        end
        if (cmd.finish)
        begin
            found          <= hit_reg;
            port_name_out  <= (hit_reg && st.is_lookup) ? rd_nm_reg : '0;
            entry_slot_out <= (hit_reg && st.is_lookup)
                              ? crh_pkg::SLOT_W'(cur_reg) : '0;
        end
    end

endmodule
`default_nettype wire

[design/chained_reverse_hash_mtf.sv]
// Channel | Ports                                                       | Handshake
// input   | kind space_id object_id port_name_in entry_slot_in          | start & !busy
// result  | found port_name_out entry_slot_out                          | done, one cycle
// An insert, or an unknown kind, goes from the head state straight to the done state.
// A lookup or delete that misses reads and checks each chain node in turn, then finishes.
// A hit adds an unlink step for a delete, and unlink and front steps when a lookup moves a node to the front.
// The chain walk reads the node store once per node visited.
// Reset empties all buckets at once; the node store needs no clearing.
// The receiver cannot stall; busy holds off new transactions.
`default_nettype none
module chained_reverse_hash_mtf
#(
    parameter int BUCKETS = crh_pkg::BUCKETS_DEF,
    parameter int NODES   = crh_pkg::NODES_DEF
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [crh_pkg::KIND_W-1:0]    kind,
    input  wire [crh_pkg::KEY_W-1:0]     space_id,
    input  wire [crh_pkg::KEY_W-1:0]     object_id,
    input  wire [crh_pkg::NAME_W-1:0]    port_name_in,
    input  wire [crh_pkg::SLOT_W-1:0]    entry_slot_in,
    output logic                         done,
    output logic                         found,
    output logic [crh_pkg::NAME_W-1:0]   port_name_out,
    output logic [crh_pkg::SLOT_W-1:0]   entry_slot_out
);

    crh_pkg::cmd_t    cmd;
    crh_pkg::status_t st;

    crh_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    crh_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .space_id       (space_id),
        .object_id      (object_id),
        .port_name_in   (port_name_in),
        .entry_slot_in  (entry_slot_in),
        .st             (st),
        .done           (done),
        .found          (found),
        .port_name_out  (port_name_out),
        .entry_slot_out (entry_slot_out)
    );

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> done)
        else $error("Result strobe missing after finish.");

    a_no_done_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("Result strobe straight after acceptance.");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("More than one datapath command at once.");

endmodule
`default_nettype wire
